### hdl/tss_pkg.sv
package tss_pkg;

    // step codes as seen on the result
    typedef logic [3:0] step_code_t;

    localparam step_code_t STEP_S0  = 4'd0;
    localparam step_code_t STEP_S10 = 4'd1;
    localparam step_code_t STEP_S11 = 4'd2;
    localparam step_code_t STEP_S20 = 4'd3;
    localparam step_code_t STEP_S21 = 4'd4;
    localparam step_code_t STEP_S30 = 4'd5;
    localparam step_code_t STEP_S31 = 4'd6;
    localparam step_code_t STEP_S40 = 4'd7;
    localparam step_code_t STEP_S41 = 4'd8;
    localparam step_code_t STEP_S42 = 4'd9;
    localparam step_code_t STEP_S50 = 4'd10;
    localparam step_code_t STEP_S51 = 4'd11;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_RUN_ENABLE      = 2'd0;
    localparam cfg_index_t CFG_RETURN_OVERRIDE = 2'd1;
    localparam cfg_index_t CFG_FIRST_HOLD      = 2'd2;
    localparam cfg_index_t CFG_SECOND_HOLD     = 2'd3;

    localparam logic [31:0] HOLD_RESET_TICKS = 32'd10000;
    localparam logic [31:0] TICKS_MAX        = 32'hFFFF_FFFF;

    // relay drive vector: vv vj vr m ecl v1 v2 at bits 0..6
    localparam int RELAY_BITS = 7;
    typedef logic [RELAY_BITS-1:0] relay_vec_t;

    typedef struct packed {
        logic read_ok;
        logic contact_a;
        logic contact_b;
        logic return_in;
    } in_item_t;

    typedef struct packed {
        step_code_t step_code;
        logic       relay_vv;
        logic       relay_vj;
        logic       relay_vr;
        logic       relay_m;
        logic       relay_ecl;
        logic       relay_v1;
        logic       relay_v2;
        logic       step_changed;
        logic       timer_running;
        logic       at_rest;
    } out_item_t;

    typedef struct packed {
        logic        run_enable;
        logic        return_override;
        logic [31:0] first_hold_ticks;
        logic [31:0] second_hold_ticks;
    } cfg_t;

    typedef struct packed {
        step_code_t  step;
        logic        timer_active;
        logic [31:0] timer_ticks;
    } seq_state_t;

    // relay pattern for each step, unknown codes drive nothing
    function automatic relay_vec_t relay_decode(input step_code_t step);
        relay_vec_t r;
        case (step)
            STEP_S0:  r = 7'h01;
            STEP_S10: r = 7'h52;
            STEP_S11: r = 7'h7C;
            STEP_S20: r = 7'h32;
            STEP_S21: r = 7'h32;
            STEP_S30: r = 7'h32;
            STEP_S31: r = 7'h7C;
            STEP_S40: r = 7'h12;
            STEP_S41: r = 7'h52;
            STEP_S42: r = 7'h32;
            STEP_S50: r = 7'h52;
            STEP_S51: r = 7'h52;
            default:  r = 7'h00;
        endcase
        return r;
    endfunction

endpackage

### hdl/tss_cfg_regs.sv
module tss_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  tss_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    output tss_pkg::cfg_t       cfg
);
    import tss_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_enable        <= 1'b0;
            cfg_reg.return_override   <= 1'b0;
            cfg_reg.first_hold_ticks  <= HOLD_RESET_TICKS;
            cfg_reg.second_hold_ticks <= HOLD_RESET_TICKS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RUN_ENABLE:      cfg_reg.run_enable        <= cfg_data[0];
                CFG_RETURN_OVERRIDE: cfg_reg.return_override   <= cfg_data[0];
                CFG_FIRST_HOLD:      cfg_reg.first_hold_ticks  <= cfg_data;
                CFG_SECOND_HOLD:     cfg_reg.second_hold_ticks <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

### hdl/tss_step_core.sv
module tss_step_core (
    input  tss_pkg::in_item_t   item,
    input  tss_pkg::cfg_t       cfg,
    input  tss_pkg::seq_state_t cur,
    output tss_pkg::seq_state_t nxt,
    output tss_pkg::out_item_t  result
);
    import tss_pkg::*;

    logic        ret;
    logic        both_off;
    logic [31:0] ticks;
    relay_vec_t  relays;

    // tick timer, step transition and result decode
    always_comb
    begin
        ret      = item.return_in | cfg.return_override;
        both_off = !item.contact_a && !item.contact_b;

        // active timer counts every tick, saturating
        ticks = cur.timer_ticks;
        if (cur.timer_active && (cur.timer_ticks != TICKS_MAX))
        begin
            ticks = cur.timer_ticks + 32'd1;
        end

        nxt.step         = cur.step;
        nxt.timer_active = cur.timer_active;
        nxt.timer_ticks  = ticks;

        if (cfg.run_enable && item.read_ok)
        begin
            case (cur.step)
                STEP_S0:
                begin
                    if (item.contact_a)
                        nxt.step = STEP_S10;
                    else if (item.contact_b)
                        nxt.step = STEP_S30;
                end
                STEP_S10:
                begin
                    if (both_off)
                    begin
                        nxt.step         = STEP_S11;
                        nxt.timer_active = 1'b1;
                        nxt.timer_ticks  = '0;
                    end
                end
                STEP_S11:
                begin
                    if (cur.timer_active && (ticks >= cfg.first_hold_ticks))
                    begin
                        nxt.timer_active = 1'b0;
                        nxt.step         = ret ? STEP_S40 : STEP_S20;
                    end
                end
                STEP_S20:
                begin
                    if (item.contact_b)
                        nxt.step = STEP_S21;
                end
                STEP_S40:
                begin
                    if (item.contact_a)
                        nxt.step = STEP_S41;
                    else if (item.contact_b)
                        nxt.step = STEP_S42;
                end
                STEP_S21, STEP_S41, STEP_S42, STEP_S51:
                begin
                    if (both_off)
                        nxt.step = STEP_S0;
                end
                STEP_S30:
                begin
                    if (both_off)
                    begin
                        nxt.step         = STEP_S31;
                        nxt.timer_active = 1'b1;
                        nxt.timer_ticks  = '0;
                    end
                end
                STEP_S31:
                begin
                    if (cur.timer_active && (ticks >= cfg.second_hold_ticks))
                    begin
                        nxt.timer_active = 1'b0;
                        nxt.step         = ret ? STEP_S40 : STEP_S50;
                    end
                end
                STEP_S50:
                begin
                    if (item.contact_a)
                        nxt.step = STEP_S51;
                end
                default:
                begin
                    nxt.step = STEP_S0;
                end
            endcase
        end

        // result fields from the new step
        relays               = relay_decode(nxt.step);
        result.step_code     = nxt.step;
        result.relay_vv      = relays[0];
        result.relay_vj      = relays[1];
        result.relay_vr      = relays[2];
        result.relay_m       = relays[3];
        result.relay_ecl     = relays[4];
        result.relay_v1      = relays[5];
        result.relay_v2      = relays[6];
        result.step_changed  = (nxt.step != cur.step);
        result.timer_running = nxt.timer_active;
        result.at_rest       = (nxt.step == STEP_S0);
    end

endmodule

### hdl/timed_step_sequencer_unit.sv
// Timed step sequencer: one request per millisecond tick, one result per request.
// A request is captured in an input register; from there the step logic updates
// the step and hold timer and loads the result register. A new request is taken
// every cycle as long as the result register is free or being taken in the same
// cycle, so the sustained rate is one request per clock. Configuration writes are
// accepted in every cycle and should be made only while no request is in flight.
module timed_step_sequencer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tss_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tss_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  tss_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data
);
    import tss_pkg::*;

    cfg_t       cfg;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  result_next;
    logic       out_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       advance;

    tss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tss_step_core u_core (
        .item   (in_item_reg),
        .cfg    (cfg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    // request moves into the result register when that register is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step         <= STEP_S0;
            state_reg.timer_active <= 1'b0;
            state_reg.timer_ticks  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result_next;
        end
    end

endmodule
